// ----- src/swsrch_pkg.sv -----
`timescale 1ns / 1ps

package swsrch_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_DUMP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;

endpackage

// ----- src/swsrch_ram.sv -----
`timescale 1ns / 1ps

module swsrch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/stack_with_search.sv -----
`timescale 1ns / 1ps

// Bounded stack of up to DEPTH signed 32-bit values with linear search and dump.
// Values live in one DEPTH x 32 RAM with a registered read; a count
// register marks the top, so the RAM needs no clearing after reset. Push and pop
// take a transaction, update the count in the same cycle and give their single
// result through the S_EMIT state and the output register. Search and dump walk
// the entries oldest first through the single RAM read port, one entry per cycle
// while the walk is not held: a search gives one result, a dump gives one
// result per entry, the final one marked by last. A result waits in the output
// register while the block continues; a dump holds its walk whenever that
// register is still occupied.
module stack_with_search #(
	parameter int DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  swsrch_pkg::action_t     action,
	input  swsrch_pkg::data_t       value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output swsrch_pkg::status_t     status,
	output swsrch_pkg::pos_t        position,
	output swsrch_pkg::data_t       entry_value,
	output logic                    last
);

	import swsrch_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   idx_next;
	action_t         act_q, act_d;
	data_t           key_q, key_d;
	status_t         pend_status_q, pend_status_d;
	pos_t            pend_pos_q, pend_pos_d;

	logic            out_valid_q, out_valid_d;
	status_t         status_q, status_d;
	pos_t            pos_q, pos_d;
	data_t           entry_q, entry_d;
	logic            last_q, last_d;

	logic            slot_free;
	logic            last_hit;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [DATA_W-1:0] rdata;

	swsrch_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign idx_next  = idx_q + CW'(1);
	assign last_hit  = (idx_next == count_q);
	assign waddr     = count_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q         <= idx_d;
		act_q         <= act_d;
		key_q         <= key_d;
		pend_status_q <= pend_status_d;
		pend_pos_q    <= pend_pos_d;
		status_q      <= status_d;
		pos_q         <= pos_d;
		entry_q       <= entry_d;
		last_q        <= last_d;
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		idx_d         = idx_q;
		act_d         = act_q;
		key_d         = key_q;
		pend_status_d = pend_status_q;
		pend_pos_d    = pend_pos_q;
		out_valid_d   = out_valid_q && !out_ready;
		status_d      = status_q;
		pos_d         = pos_q;
		entry_d       = entry_q;
		last_d        = last_q;
		in_ready      = 1'b0;
		we            = 1'b0;
		raddr         = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				raddr    = '0;
				if (in_valid) begin
					act_d         = action;
					key_d         = value;
					idx_d         = '0;
					pend_pos_d    = '0;
					pend_status_d = STAT_OK;
					state_d       = S_EMIT;
					case (action)
						ACT_PUSH: begin
							if (count_q == FULL_CNT) begin
								pend_status_d = STAT_FULL;
							end else begin
								we      = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								pend_status_d = STAT_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						default: begin
							if (count_q == '0) begin
								pend_status_d = STAT_EMPTY;
							end else begin
								state_d = S_SCAN;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				if (act_q == ACT_SEARCH) begin
					if (rdata == key_q) begin
						pend_status_d = STAT_OK;
						pend_pos_d    = POS_W'(idx_next);
						state_d       = S_EMIT;
					end else if (last_hit) begin
						pend_status_d = STAT_NOTFOUND;
						pend_pos_d    = '0;
						state_d       = S_EMIT;
					end else begin
						idx_d = idx_next;
						raddr = idx_next[AW-1:0];
					end
				end else if (slot_free) begin
					out_valid_d = 1'b1;
					status_d    = STAT_OK;
					pos_d       = '0;
					entry_d     = rdata;
					last_d      = last_hit;
					if (last_hit) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_next;
						raddr = idx_next[AW-1:0];
					end
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					status_d    = pend_status_q;
					pos_d       = pend_pos_q;
					entry_d     = '0;
					last_d      = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = pos_q;
	assign entry_value = entry_q;
	assign last        = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count above depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q < count_q)
		else $error("scan index past top");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_PUSH && count_q != FULL_CNT
		|=> count_q == $past(count_q) + CW'(1))
		else $error("push did not advance count");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> last && entry_value == '0)
		else $error("empty result malformed");

endmodule

// ----- tb/tb_stack_with_search.sv -----
`timescale 1ns / 1ps

module tb_stack_with_search;
	import swsrch_pkg::*;

	localparam int DEPTH       = 64;
	localparam int RAND_ITEMS  = 245;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = DEPTH + 8;

	typedef struct {
		status_t status;
		pos_t    position;
		data_t   entry_value;
		logic    last;
	} stack_result_t;

	typedef struct {
		action_t act;
		data_t   val;
		bit      typed;
		status_t st;
		pos_t    pos;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	action_t action;
	data_t   value;
	logic    out_valid;
	logic    out_ready = 1'b0;
	status_t status;
	pos_t    position;
	data_t   entry_value;
	logic    last;

	data_t         shadow_entries [DEPTH];
	int            shadow_count = 0;
	stack_result_t owed_results [$];
	stack_result_t front_res;
	int            mismatch_cnt = 0;
	int            quiet_cycles = 0;
	int            item_idx = 0;
	int            tx_idle_pct = 12;
	int            rx_stall_pct = 85;

	dir_row_t dir_rows [25] = '{
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_EMPTY,    7'd0},
		'{ACT_SEARCH, 32'sh00000000, 1'b1, STAT_EMPTY,    7'd0},
		'{ACT_DUMP,   32'sh00000000, 1'b1, STAT_EMPTY,    7'd0},
		'{ACT_PUSH,   32'sh7fffffff, 1'b1, STAT_OK,       7'd0},
		'{ACT_PUSH,   32'sh80000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_PUSH,   32'sh00000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_PUSH,   32'shffffffff, 1'b1, STAT_OK,       7'd0},
		'{ACT_PUSH,   32'sh7fffffff, 1'b1, STAT_OK,       7'd0},
		'{ACT_SEARCH, 32'sh7fffffff, 1'b1, STAT_OK,       7'd1},
		'{ACT_SEARCH, 32'sh80000000, 1'b1, STAT_OK,       7'd2},
		'{ACT_SEARCH, 32'shffffffff, 1'b1, STAT_OK,       7'd4},
		'{ACT_SEARCH, 32'sh12345678, 1'b1, STAT_NOTFOUND, 7'd0},
		'{ACT_DUMP,   32'sh00000000, 1'b0, STAT_OK,       7'd0},
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_SEARCH, 32'sh7fffffff, 1'b1, STAT_OK,       7'd1},
		'{ACT_DUMP,   32'shffffffff, 1'b0, STAT_OK,       7'd0},
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_OK,       7'd0},
		'{ACT_POP,    32'sh00000000, 1'b1, STAT_EMPTY,    7'd0},
		'{ACT_PUSH,   32'sh55555555, 1'b1, STAT_OK,       7'd0},
		'{ACT_PUSH,   32'shaaaaaaaa, 1'b1, STAT_OK,       7'd0},
		'{ACT_POP,    32'shffffffff, 1'b1, STAT_OK,       7'd0},
		'{ACT_DUMP,   32'sh00000000, 1'b0, STAT_OK,       7'd0}
	};

	stack_with_search #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.entry_value(entry_value),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void apply_stack_op(action_t a, data_t v);
		stack_result_t r;
		int i;
		r = '{STAT_OK, '0, '0, 1'b1};
		case (a)
			ACT_PUSH: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_entries[shadow_count] = v;
					shadow_count++;
				end
			end
			ACT_POP: begin
				if (shadow_count == 0) r.status = STAT_EMPTY;
				else shadow_count--;
			end
			ACT_SEARCH: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.status = STAT_NOTFOUND;
					for (i = 0; i < shadow_count; i++) begin
						if (shadow_entries[i] == v) begin
							r.status   = STAT_OK;
							r.position = pos_t'(i + 1);
							break;
						end
					end
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					for (i = 0; i < shadow_count; i++) begin
						r.entry_value = shadow_entries[i];
						r.last        = (i == shadow_count - 1);
						owed_results.push_back(r);
					end
					return;
				end
			end
		endcase
		owed_results.push_back(r);
	endfunction

	function automatic data_t pick_value(bit as_key);
		int r;
		r = $urandom_range(0, 99);
		if (as_key && shadow_count > 0 && r < 50)
			return shadow_entries[$urandom_range(0, shadow_count - 1)];
		r = $urandom_range(0, 99);
		if (r < 40)
			return data_t'(int'($urandom_range(0, 15)) - 8);
		if (r < 55) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh00000000;
				default: return 32'shffffffff;
			endcase
		end
		return data_t'($urandom);
	endfunction

	task automatic send_item(action_t a, data_t v, bit typed, stack_result_t typed_res);
		if (item_idx >= 200) begin
			tx_idle_pct  = 0;
			rx_stall_pct = 0;
		end else if (item_idx >= 100) begin
			tx_idle_pct  = 85;
			rx_stall_pct = 12;
		end
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		action   <= a;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		apply_stack_op(a, v);
		if (typed) begin
			void'(owed_results.pop_back());
			owed_results.push_back(typed_res);
		end
		item_idx++;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result: status=%0d position=%0d value=%0d last=%0d",
					$time, status, position, entry_value, last);
				mismatch_cnt++;
			end else begin
				front_res = owed_results.pop_front();
				if (status !== front_res.status || position !== front_res.position ||
						entry_value !== front_res.entry_value || last !== front_res.last) begin
					$display("%0t: mismatch: expected status=%0d position=%0d value=%0d last=%0d",
						$time, front_res.status, front_res.position,
						front_res.entry_value, front_res.last);
					$display("%0t:           actual   status=%0d position=%0d value=%0d last=%0d",
						$time, status, position, entry_value, last);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int k;
		int r;
		int full_pushes;
		int empty_pops;
		bit filling;
		action_t a;
		stack_result_t typed_res;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		action   = ACT_PUSH;
		value    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			typed_res = '{dir_rows[k].st, dir_rows[k].pos, '0, 1'b1};
			send_item(dir_rows[k].act, dir_rows[k].val, dir_rows[k].typed, typed_res);
		end

		// fill to full, then drain to empty, and repeat
		filling     = 1'b1;
		full_pushes = 0;
		empty_pops  = 0;
		typed_res   = '{STAT_OK, '0, '0, 1'b1};
		for (k = 0; k < RAND_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			if (filling)
				a = (r < 80) ? ACT_PUSH : (r < 92) ? ACT_SEARCH : (r < 96) ? ACT_POP : ACT_DUMP;
			else
				a = (r < 70) ? ACT_POP : (r < 85) ? ACT_SEARCH : (r < 95) ? ACT_PUSH : ACT_DUMP;
			if (a == ACT_PUSH && shadow_count == DEPTH) full_pushes++;
			if (a == ACT_POP && shadow_count == 0) empty_pops++;
			if (filling && full_pushes >= 3) begin
				filling    = 1'b0;
				empty_pops = 0;
			end else if (!filling && empty_pops >= 2) begin
				filling     = 1'b1;
				full_pushes = 0;
			end
			send_item(a, pick_value(a == ACT_SEARCH), 1'b0, typed_res);
		end
		in_valid <= 1'b0;

		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
